[hw/rtl/pqep_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pqep_pkg;
  localparam int CORNERS_PER_QUAD = 4;
  localparam int PROJ_SCALE = 30;
  localparam int CFG_ROW_X = 0;
  localparam int CFG_ROW_Y = 1;
  localparam int CFG_ROW_Z = 2;
  localparam int CFG_CENTER = 3;
  localparam int ACC_W = 35;
  localparam int NUM_W = 43;
  localparam int Q_W = 44;

  typedef struct packed {
    logic start;
    logic signed [NUM_W-1:0] num;
    logic signed [ACC_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic signed [15:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

[hw/rtl/pqep_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// Restoring signed divider, truncating toward zero, saturated to 16 bits.
// Four quotient bits per cycle.
module pqep_divider (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pqep_pkg::div_req_t req,
  output pqep_pkg::div_rsp_t      rsp
);
  localparam int NW = pqep_pkg::NUM_W;
  localparam int QW = pqep_pkg::Q_W;
  localparam int DW = pqep_pkg::ACC_W;
  localparam int STEPS = QW / 4;

  logic [QW-1:0] q_r, q_nxt;
  logic [DW:0] rem_r, rem_nxt;
  logic [DW-1:0] d_r;
  logic neg_r, busy_r, done_r;
  logic [3:0] cnt_r;
  logic [15:0] quot_r;
  logic [QW-1:0] qf;
  logic [QW:0] qs;

  always_comb begin
    logic [DW+1:0] t;
    q_nxt = q_r;
    rem_nxt = rem_r;
    for (int i = 0; i < 4; i++) begin
      t = {rem_nxt, q_nxt[QW-1]};
      q_nxt = {q_nxt[QW-2:0], 1'b0};
      if (t >= {2'b00, d_r}) begin
        t = t - {2'b00, d_r};
        q_nxt[0] = 1'b1;
      end
      rem_nxt = t[DW:0];
    end
  end

  assign qf = q_nxt;
  assign qs = neg_r ? -{1'b0, qf} : {1'b0, qf};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
        neg_r <= req.num[NW-1] ^ req.den[DW-1];
        q_r <= req.num[NW-1] ? QW'(-{{(QW-NW){req.num[NW-1]}}, req.num})
                             : QW'(req.num);
        d_r <= req.den[DW-1] ? DW'(-req.den) : DW'(req.den);
        rem_r <= '0;
      end else if (busy_r) begin
        q_r <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (!qs[QW] && qs[QW-1:15] != '0) quot_r <= 16'sh7FFF;
          else if (qs[QW] && qs[QW-1:15] != '1) quot_r <= 16'sh8000;
          else quot_r <= qs[15:0];
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
endmodule
`default_nettype wire

[hw/rtl/perspective_quad_edge_projector.sv]
`timescale 1ns / 1ps
`default_nettype none
// Projects Q8.8 homogeneous vertices through a 3-row camera matrix and emits
// quad edges. After a vertex transfer, the multiply-accumulate steps run on one
// shared 16x16 multiplier. Two divisions follow on one shared divider. in_tready
// returns once the divisions are done and any edges of the corner (none for the
// first corner, one, or two at quad close) are accepted on out_tready. With zero
// depth the divisions are not waited on. Zero depth saturates the coordinate, or
// gives the center when its accumulator is zero, and sets depth_fault.
module perspective_quad_edge_projector (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // vx, vy, vz, vw
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0] out_tdata,       // start_x, start_y, end_x, end_y
  output logic             out_tlast,  // quad_done
  output logic             out_tuser,  // depth_fault
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);
  localparam int AW = pqep_pkg::ACC_W;
  localparam int NW = pqep_pkg::NUM_W;

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_DIVX, S_DIVY, S_OUT1, S_OUT2}
    state_t;

  state_t state_r;
  logic [63:0] rowx_r, rowy_r, rowz_r, v_r;
  logic [7:0] center_r;
  logic [3:0] mac_r;
  logic signed [AW-1:0] acc_r [3];
  logic signed [31:0] prod;
  logic signed [15:0] ca, cb;
  logic [1:0] cnt_r, faults_r;
  logic [15:0] fx_r, fy_r, px_r, py_r, cx_r, cy_r;
  logic zf;
  logic divst_r;
  pqep_pkg::div_req_t dreq;
  pqep_pkg::div_rsp_t drsp;
  logic signed [NW-1:0] numv;
  logic signed [AW-1:0] asel;
  logic [15:0] zres;

  always_comb begin
    logic [63:0] row;
    unique case (mac_r[3:2])
      2'd0: row = rowx_r;
      2'd1: row = rowy_r;
      default: row = rowz_r;
    endcase
    ca = row[16*mac_r[1:0] +: 16];
    cb = v_r[16*mac_r[1:0] +: 16];
  end
  assign prod = ca * cb;

  assign zf = (acc_r[2] == '0);
  assign asel = (state_r == S_DIVY) ? acc_r[1] : acc_r[0];
  assign numv = NW'($signed({1'b0, center_r})) * acc_r[2]
              - NW'(asel) * pqep_pkg::PROJ_SCALE;
  assign zres = (asel == '0) ? {8'd0, center_r} :
                asel[AW-1] ? 16'h7FFF : 16'h8000;
  assign dreq.start = divst_r;
  assign dreq.num = numv;
  assign dreq.den = acc_r[2];

  pqep_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rowx_r <= 64'd256;
      rowy_r <= 64'd1 << 24;
      rowz_r <= 64'd1 << 40;
      center_r <= 8'd64;
      cnt_r <= '0;
      faults_r <= '0;
      fx_r <= '0; fy_r <= '0; px_r <= '0; py_r <= '0;
      divst_r <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      divst_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          2'(pqep_pkg::CFG_ROW_X): rowx_r <= cfg_wdata;
          2'(pqep_pkg::CFG_ROW_Y): rowy_r <= cfg_wdata;
          2'(pqep_pkg::CFG_ROW_Z): rowz_r <= cfg_wdata;
          default: center_r <= cfg_wdata[7:0];
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          v_r <= in_tdata;
          mac_r <= '0;
          for (int i = 0; i < 3; i++) acc_r[i] <= '0;
          state_r <= S_MAC;
        end
        S_MAC: begin
          acc_r[mac_r[3:2]] <= acc_r[mac_r[3:2]] + AW'(prod);
          mac_r <= mac_r + 4'd1;
          if (mac_r == 4'd11) begin
            state_r <= S_DIVX;
            divst_r <= 1'b1;
          end
        end
        S_DIVX: if (zf) begin
          cx_r <= zres;
          state_r <= S_DIVY;
          divst_r <= 1'b1;
        end else if (drsp.done) begin
          cx_r <= drsp.quot;
          state_r <= S_DIVY;
          divst_r <= 1'b1;
        end
        S_DIVY: if (zf || drsp.done) begin
          logic [15:0] cy;
          cy = zf ? zres : drsp.quot;
          cy_r <= cy;
          if (cnt_r == 2'd0) begin
            fx_r <= cx_r; fy_r <= cy; px_r <= cx_r; py_r <= cy;
            faults_r <= {zf, zf};
            cnt_r <= 2'd1;
            state_r <= S_IDLE;
          end else begin
            out_tdata <= {cy, cx_r, py_r, px_r};
            out_tlast <= 1'b0;
            out_tuser <= faults_r[1] | zf;
            out_tvalid <= 1'b1;
            state_r <= S_OUT1;
          end
        end
        S_OUT1: if (out_tready) begin
          if (cnt_r >= 2'(pqep_pkg::CORNERS_PER_QUAD - 1)) begin
            out_tdata <= {fy_r, fx_r, cy_r, cx_r};
            out_tlast <= 1'b1;
            out_tuser <= faults_r[0] | zf;
            cnt_r <= '0;
            state_r <= S_OUT2;
          end else begin
            out_tvalid <= 1'b0;
            px_r <= cx_r; py_r <= cy_r;
            faults_r <= {zf, faults_r[0]};
            cnt_r <= cnt_r + 2'd1;
            state_r <= S_IDLE;
          end
        end
        S_OUT2: if (out_tready) begin
          out_tvalid <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);

`ifndef NO_ASSERTIONS
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("ready while result pending");
  a_last_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> cnt_r == 2'd0) else $error("count not cleared");
`endif
endmodule
`default_nettype wire

[tb/perspective_quad_edge_projector_tb.sv]
`timescale 1ns / 1ps
module perspective_quad_edge_projector_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // vx, vy, vz, vw
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // start_x, start_y, end_x, end_y
  logic        out_tlast;       // quad_done
  logic        out_tuser;       // depth_fault
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  perspective_quad_edge_projector dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic        fault;
    logic        done;
    logic [63:0] coords;
  } edge_t;

  typedef struct {
    logic [63:0] vtx;
    logic        known;
    edge_t       e0;
  } vec_row_t;

  edge_t       edge_q[$];
  int          errors = 0;
  logic        quiet = 1'b0;

  logic [63:0] m_row[3];
  logic [7:0]  m_center;
  logic [1:0]  m_count;
  logic [15:0] m_first_x, m_first_y, m_prev_x, m_prev_y;
  logic [1:0]  m_faults;

  function automatic logic signed [47:0] row_dot(logic [63:0] row, logic [63:0] v);
    logic signed [47:0] acc;
    acc = 0;
    for (int i = 0; i < 4; i++)
      acc += 48'(signed'(row[16*i +: 16])) * 48'(signed'(v[16*i +: 16]));
    return acc;
  endfunction

  function automatic logic [15:0] screen_coord(logic signed [47:0] a,
                                               logic signed [47:0] z);
    logic signed [63:0] n, q;
    if (z == 0) begin
      n = -64'sd30 * 64'(a);
      if (n > 0) return 16'h7fff;
      if (n < 0) return 16'h8000;
      return {8'd0, m_center};
    end
    n = 64'(signed'({1'b0, m_center})) * 64'(z) - 64'sd30 * 64'(a);
    q = n / 64'(z);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  task automatic predict_vertex(logic [63:0] v);
    logic signed [47:0] xp, yp, zp;
    logic [15:0] cx, cy;
    logic f;
    xp = row_dot(m_row[0], v);
    yp = row_dot(m_row[1], v);
    zp = row_dot(m_row[2], v);
    cx = screen_coord(xp, zp);
    cy = screen_coord(yp, zp);
    f = (zp == 0);
    if (m_count == 0) begin
      m_first_x = cx; m_prev_x = cx;
      m_first_y = cy; m_prev_y = cy;
      m_faults = {f, f};
      m_count = 1;
    end else begin
      edge_q.push_back('{fault: m_faults[1] | f, done: 1'b0,
                         coords: {cy, cx, m_prev_y, m_prev_x}});
      if (m_count >= pqep_pkg::CORNERS_PER_QUAD - 1) begin
        edge_q.push_back('{fault: m_faults[0] | f, done: 1'b1,
                           coords: {m_first_y, m_first_x, cy, cx}});
        m_count = 0;
      end else begin
        m_prev_x = cx; m_prev_y = cy;
        m_faults[1] = f;
        m_count++;
      end
    end
  endtask

  task automatic write_reg(int idx, logic [63:0] val);
    cfg_we <= 1'b1; cfg_index <= idx[1:0]; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pqep_pkg::CFG_ROW_X: m_row[0] = val;
      pqep_pkg::CFG_ROW_Y: m_row[1] = val;
      pqep_pkg::CFG_ROW_Z: m_row[2] = val;
      pqep_pkg::CFG_CENTER: m_center = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (edge_q.size() != 0 && guard < 200000) begin
      @(posedge clk); guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic send_vertex(logic [63:0] v);
    if (!quiet && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 14)) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
    predict_vertex(v);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // result checker with random backpressure
  int stall = 0;
  always @(posedge clk) begin
    edge_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (edge_q.size() == 0) begin
        $display("%0t: unexpected edge actual %h last %b user %b", $time,
                 out_tdata, out_tlast, out_tuser);
        errors++;
      end else begin
        e = edge_q.pop_front();
        if (out_tdata !== e.coords) begin
          $display("%0t: tdata expected %h actual %h", $time, e.coords, out_tdata);
          errors++;
        end
        if (out_tlast !== e.done) begin
          $display("%0t: quad_done expected %b actual %b", $time, e.done, out_tlast);
          errors++;
        end
        if (out_tuser !== e.fault) begin
          $display("%0t: depth_fault expected %b actual %b", $time, e.fault,
                   out_tuser);
          errors++;
        end
      end
    end
    if (stall > 0) begin
      stall <= stall - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall <= $urandom_range(1, 14) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [63:0] rand_lanes();
    return {$urandom(), $urandom()};
  endfunction

  // small coefficient and coordinate lanes keep most projections on screen
  function automatic logic [15:0] mild();
    return 16'($signed($urandom_range(0, 2047)) - 1024);
  endfunction

  function automatic logic [63:0] mild_vertex();
    return {16'sh0100, mild(), mild(), mild()};
  endfunction

  vec_row_t dir_tab[$];

  initial begin
    logic [63:0] v;
    m_row[0] = 64'd256; m_row[1] = 64'd1 << 24; m_row[2] = 64'd1 << 40;
    m_center = 8'd64; m_count = 0; m_faults = 0;
    m_first_x = 0; m_first_y = 0; m_prev_x = 0; m_prev_y = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero vertex: z' = 0, a' = 0 -> center, faulted
    dir_tab.push_back('{64'h0, 1'b0, '0});
    dir_tab.push_back('{64'h0, 1'b1,
      '{fault: 1'b1, done: 1'b0, coords: {16'd64, 16'd64, 16'd64, 16'd64}}});
    dir_tab.push_back('{64'h0000_0100_0000_0100, 1'b0, '0});
    dir_tab.push_back('{64'h0000_0100_ff00_0100, 1'b0, '0});
    dir_tab.push_back('{64'h7fff_7fff_7fff_7fff, 1'b0, '0});
    dir_tab.push_back('{64'h8000_8000_8000_8000, 1'b0, '0});
    dir_tab.push_back('{64'h0000_0000_7fff_8000, 1'b0, '0});
    dir_tab.push_back('{64'h0000_0001_8000_7fff, 1'b0, '0});
    dir_tab.push_back('{64'h0000_ffff_0001_0001, 1'b0, '0});
    dir_tab.push_back('{64'h0000_0000_0000_0000, 1'b0, '0});
    dir_tab.push_back('{64'h1234_0200_0080_ff80, 1'b0, '0});
    dir_tab.push_back('{64'hffff_0000_0100_0000, 1'b0, '0});
    foreach (dir_tab[i]) begin
      if (dir_tab[i].known) begin
        predict_vertex(64'h0);
        void'(edge_q.pop_back());
        edge_q.push_back(dir_tab[i].e0);
        in_tvalid <= 1'b1; in_tdata <= dir_tab[i].vtx;
        do @(posedge clk); while (!in_tready);
        in_tvalid <= 1'b0;
        @(posedge clk);
      end else begin
        send_vertex(dir_tab[i].vtx);
      end
    end
    drain();

    // extreme register settings
    write_reg(pqep_pkg::CFG_ROW_X, 64'hffff_ffff_ffff_ffff);
    write_reg(pqep_pkg::CFG_ROW_Y, 64'h8000_8000_8000_8000);
    write_reg(pqep_pkg::CFG_ROW_Z, 64'h7fff_7fff_7fff_7fff);
    write_reg(pqep_pkg::CFG_CENTER, 64'hff);
    for (int i = 0; i < 16; i++) send_vertex(rand_lanes());
    drain();
    write_reg(pqep_pkg::CFG_CENTER, 64'h0);
    write_reg(pqep_pkg::CFG_ROW_Z, 64'h0);
    for (int i = 0; i < 8; i++) send_vertex(rand_lanes());
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      write_reg(pqep_pkg::CFG_ROW_X,
                {16'($urandom_range(0, 1023)), mild(), mild(), mild()});
      write_reg(pqep_pkg::CFG_ROW_Y,
                {16'($urandom_range(0, 1023)), mild(), mild(), mild()});
      write_reg(pqep_pkg::CFG_ROW_Z, phase == 0 ? rand_lanes()
                                      : {16'sh0400, mild(), mild(), mild()});
      write_reg(pqep_pkg::CFG_CENTER, 64'($urandom_range(0, 255)));
      if (phase == 5) quiet = 1'b1;
      for (int i = 0; i < 240; i++) begin
        case ($urandom_range(0, 9))
          0: v = rand_lanes();
          1: v = 64'h0;
          default: v = mild_vertex();
        endcase
        send_vertex(v);
        if (phase == 2 && i == 100) begin
          while (edge_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0 && edge_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
